@@ rtl/core/gphid_pkg.sv @@
// Shared types and constants of the gamepad report decoder.
`timescale 1ns / 1ps

package gphid_pkg;

    localparam logic [7:0] ID_FULL_USB = 8'h01;
    localparam logic [7:0] ID_FULL_ALT = 8'h31;

    localparam int unsigned NUM_FIELDS = 9;

    localparam logic [7:0] NEED_REDUCED = 8'd10;
    localparam logic [7:0] NEED_USB     = 8'd11;
    localparam logic [7:0] NEED_ALT     = 8'd12;

    localparam int unsigned RESULT_BITS = 95;
    localparam int unsigned RESULT_BYTES_W = 96;

    typedef struct packed {
        logic [7:0]                       id;
        logic [7:0]                       size;
        logic [NUM_FIELDS-1:0][7:0]       fields;
    } t_snap;

    typedef struct packed {
        logic [13:0] buttons;
        logic [7:0]  trig_right;
        logic [7:0]  trig_left;
        logic [15:0] right_y;
        logic [15:0] right_x;
        logic [15:0] left_y;
        logic [15:0] left_x;
        logic        valid_res;
    } t_result;

endpackage

@@ rtl/core/gamepad_hid_report_decoder_core.sv @@
// Top level of the gamepad input report decoder.
`timescale 1ns / 1ps

// The block takes an input report one byte per transfer, report id first, with
// tlast on the final byte, and gives one decoded result transfer per report.
// Every byte is held in the input register; when it moves on, the capture
// registers are updated and, on the last byte, the decoded result is loaded
// into the output register. A byte can be taken every cycle, but a last byte
// waits in the input register while an earlier result is still stalled at the
// output. An unknown report id or a report shorter than its layout gives a
// result with every field zero. Bytes beyond MAX_REPORT_BYTES are ignored.
// The link type is written through the configuration channel; the user must
// write it only while no report is in progress, as the block does not enforce
// this itself.

module gamepad_hid_report_decoder_core #(
    parameter int MAX_REPORT_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // report_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // From bit 0: valid_res, left_x, left_y, right_x, right_y, trig_left,
    // trig_right, buttons, one zero pad bit.
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // bluetooth_link
);

    logic       r_bluetooth_link;
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       r_out_valid;
    gphid_pkg::t_result r_out;

    logic               out_free;
    logic               s1_adv;
    logic               s1_update;
    gphid_pkg::t_snap   snap;
    gphid_pkg::t_result result;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_adv        = !r_s1_last || out_free;
    assign s1_update     = r_s1_valid && s1_adv;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign o_cfg_ready   = 1'b1;

    gphid_capture #(
        .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
    ) u_capture (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_update         (s1_update),
        .i_byte           (r_s1_byte),
        .i_last           (r_s1_last),
        .i_bluetooth_link (r_bluetooth_link),
        .o_snap           (snap)
    );

    gphid_decode u_decode (
        .i_snap           (snap),
        .i_bluetooth_link (r_bluetooth_link),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bluetooth_link <= 1'b0;
            r_s1_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bluetooth_link <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (s1_update && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_byte <= s_axis_tdata;
            r_s1_last <= s_axis_tlast;
        end
        if (s1_update && r_s1_last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

endmodule

@@ rtl/core/gphid_capture.sv @@
// Byte counter, report id and field capture registers of the report decoder.
`timescale 1ns / 1ps

module gphid_capture #(
    parameter int MAX_REPORT_BYTES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_update,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_bluetooth_link,
    output gphid_pkg::t_snap o_snap
);

    logic [7:0] r_count;
    logic [7:0] r_id;
    logic [gphid_pkg::NUM_FIELDS-1:0][7:0] r_fields;

    logic [7:0] n_count;
    logic [7:0] n_id;
    logic [gphid_pkg::NUM_FIELDS-1:0][7:0] n_fields;

    logic       in_range;
    logic [7:0] base;
    logic [7:0] rel;
    logic       simple;
    logic       wr_en;
    logic [3:0] wr_idx;
    logic [7:0] size;

    always_comb begin
        in_range = r_count < 8'(MAX_REPORT_BYTES);
        base     = (r_id == gphid_pkg::ID_FULL_ALT) ? 8'd2 : 8'd1;
        simple   = (r_id == gphid_pkg::ID_FULL_USB) && i_bluetooth_link;
        rel      = r_count - base;
        wr_en    = 1'b0;
        wr_idx   = 4'd0;
        if (in_range && r_count != 8'd0 && r_count >= base) begin
            if (simple) begin
                if (rel < 8'd9) begin
                    wr_en  = 1'b1;
                    wr_idx = rel[3:0];
                end
            end else if (rel < 8'd6) begin
                wr_en  = 1'b1;
                wr_idx = rel[3:0];
            end else if (rel >= 8'd7 && rel < 8'd10) begin
                wr_en  = 1'b1;
                wr_idx = rel[3:0] - 4'd1;
            end
        end

        n_id = (in_range && r_count == 8'd0) ? i_byte : r_id;
        for (int k = 0; k < gphid_pkg::NUM_FIELDS; k++) begin
            n_fields[k] = (wr_en && wr_idx == 4'(k)) ? i_byte : r_fields[k];
        end
        size    = in_range ? r_count + 8'd1 : r_count;
        n_count = i_last ? 8'd0 : size;

        o_snap.id     = n_id;
        o_snap.size   = size;
        o_snap.fields = n_fields;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 8'd0;
            r_id    <= 8'd0;
        end else if (i_update) begin
            r_count <= n_count;
            r_id    <= n_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update) begin
            r_fields <= n_fields;
        end
    end

endmodule

@@ rtl/core/gphid_decode.sv @@
// Layout selection, stick scaling and button mapping of a finished report.
`timescale 1ns / 1ps

module gphid_decode (
    input  gphid_pkg::t_snap   i_snap,
    input  logic               i_bluetooth_link,
    output gphid_pkg::t_result o_result
);

    function automatic logic [15:0] axis_right_pos(input logic [7:0] raw);
        logic [7:0] c;
        begin
            c = raw ^ 8'h80;
            axis_right_pos = (raw == 8'd0) ? 16'h8001 : {c, 8'h00};
        end
    endfunction

    function automatic logic [15:0] axis_up_pos(input logic [7:0] raw);
        logic [7:0] c;
        begin
            c = 8'h80 - raw;
            axis_up_pos = (raw == 8'd0) ? 16'h7FFF : {c, 8'h00};
        end
    endfunction

    function automatic logic [13:0] map_buttons(input logic [7:0] face,
                                                input logic [7:0] shoulder,
                                                input logic [7:0] misc);
        logic [13:0] m;
        begin
            m = 14'd0;
            case (face[3:0])
                4'd0:    m[3:0] = 4'b0001;
                4'd1:    m[3:0] = 4'b1001;
                4'd2:    m[3:0] = 4'b1000;
                4'd3:    m[3:0] = 4'b1010;
                4'd4:    m[3:0] = 4'b0010;
                4'd5:    m[3:0] = 4'b0110;
                4'd6:    m[3:0] = 4'b0100;
                4'd7:    m[3:0] = 4'b0101;
                default: m[3:0] = 4'b0000;
            endcase
            m[6]  = face[4];
            m[4]  = face[5];
            m[5]  = face[6];
            m[7]  = face[7];
            m[8]  = shoulder[0];
            m[9]  = shoulder[1];
            m[10] = shoulder[4] | misc[1];
            m[11] = shoulder[5];
            m[12] = shoulder[6];
            m[13] = shoulder[7];
            map_buttons = m;
        end
    endfunction

    logic       simple;
    logic       known;
    logic [7:0] need;

    always_comb begin
        simple = (i_snap.id == gphid_pkg::ID_FULL_USB) && i_bluetooth_link;
        known  = (i_snap.id == gphid_pkg::ID_FULL_USB) || (i_snap.id == gphid_pkg::ID_FULL_ALT);
        if (simple) begin
            need = gphid_pkg::NEED_REDUCED;
        end else if (i_snap.id == gphid_pkg::ID_FULL_ALT) begin
            need = gphid_pkg::NEED_ALT;
        end else begin
            need = gphid_pkg::NEED_USB;
        end

        o_result = '0;
        if (known && i_snap.size >= need) begin
            o_result.valid_res = 1'b1;
            o_result.left_x    = axis_right_pos(i_snap.fields[0]);
            o_result.left_y    = axis_up_pos(i_snap.fields[1]);
            o_result.right_x   = axis_right_pos(i_snap.fields[2]);
            o_result.right_y   = axis_up_pos(i_snap.fields[3]);
            if (simple) begin
                o_result.trig_left  = i_snap.fields[7];
                o_result.trig_right = i_snap.fields[8];
                o_result.buttons = map_buttons(i_snap.fields[4], i_snap.fields[5],
                                               i_snap.fields[6]);
            end else begin
                o_result.trig_left  = i_snap.fields[4];
                o_result.trig_right = i_snap.fields[5];
                o_result.buttons = map_buttons(i_snap.fields[6], i_snap.fields[7],
                                               i_snap.fields[8]);
            end
        end
    end

endmodule

@@ rtl/core/gphid_checker.sv @@
// Port-level checks of the gamepad report decoder and their binding.
`timescale 1ns / 1ps

module gphid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result transfer changed.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[95:1] == 95'd0)
        else $error("Rejected report carries nonzero fields.");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:1] != 16'h8000 && m_axis_tdata[32:17] != 16'h8000
            && m_axis_tdata[48:33] != 16'h8000 && m_axis_tdata[64:49] != 16'h8000)
        else $error("Stick axis outside the clamped range.");

    a_hat_opposed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[81] && m_axis_tdata[82])
            && !(m_axis_tdata[83] && m_axis_tdata[84]))
        else $error("Opposite hat directions set together.");

endmodule

bind gamepad_hid_report_decoder_core gphid_checker u_gphid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/gamepad_hid_report_decoder_core_test.sv @@
// Self-checking testbench of the gamepad report decoder core.
`timescale 1ns / 1ps

module gamepad_hid_report_decoder_core_test;

    localparam int CLK_PERIOD    = 12;
    localparam int REPORT_LIMIT  = 128;
    localparam int HOLD_CYCLES   = 4;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int LONG_REPORT   = 140;

    localparam int BTN_UP        = 0;
    localparam int BTN_DOWN      = 1;
    localparam int BTN_LEFT      = 2;
    localparam int BTN_RIGHT     = 3;
    localparam int BTN_A         = 4;
    localparam int BTN_B         = 5;
    localparam int BTN_X         = 6;
    localparam int BTN_Y         = 7;
    localparam int BTN_LSHOULDER = 8;
    localparam int BTN_RSHOULDER = 9;
    localparam int BTN_BACK      = 10;
    localparam int BTN_START     = 11;
    localparam int BTN_LTHUMB    = 12;
    localparam int BTN_RTHUMB    = 13;

    typedef enum logic [3:0] {
        HAT_UP, HAT_UP_RIGHT, HAT_RIGHT, HAT_DOWN_RIGHT,
        HAT_DOWN, HAT_DOWN_LEFT, HAT_LEFT, HAT_UP_LEFT
    } t_hat;

    typedef logic [7:0] t_report_q[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    gamepad_hid_report_decoder_core #(
        .MAX_REPORT_BYTES(REPORT_LIMIT)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    int        errors = 0;
    int        bytes_sent = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        idle_cycles = 0;

    bit        link_bt = 1'b0;
    int        rpt_len = 0;
    logic [7:0] rpt_id = '0;
    logic [7:0] rpt_fields [gphid_pkg::NUM_FIELDS];
    gphid_pkg::t_result decoded_q [$];
    gphid_pkg::t_result want;
    gphid_pkg::t_result got;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [15:0] scale_axis(input logic [7:0] raw, input bit invert_y);
        int centred;
        centred = invert_y ? 128 - int'(raw) : int'(raw) - 128;
        centred = centred * 256;
        if (centred > 32767) centred = 32767;
        if (centred < -32767) centred = -32767;
        return centred[15:0];
    endfunction

    function automatic logic [13:0] map_hid_buttons(input logic [7:0] face,
                                                    input logic [7:0] shoulder,
                                                    input logic [7:0] misc);
        logic [13:0] mask;
        mask = '0;
        case (face[3:0])
            HAT_UP:         mask[BTN_UP] = 1'b1;
            HAT_UP_RIGHT:   begin mask[BTN_UP] = 1'b1; mask[BTN_RIGHT] = 1'b1; end
            HAT_RIGHT:      mask[BTN_RIGHT] = 1'b1;
            HAT_DOWN_RIGHT: begin mask[BTN_DOWN] = 1'b1; mask[BTN_RIGHT] = 1'b1; end
            HAT_DOWN:       mask[BTN_DOWN] = 1'b1;
            HAT_DOWN_LEFT:  begin mask[BTN_DOWN] = 1'b1; mask[BTN_LEFT] = 1'b1; end
            HAT_LEFT:       mask[BTN_LEFT] = 1'b1;
            HAT_UP_LEFT:    begin mask[BTN_UP] = 1'b1; mask[BTN_LEFT] = 1'b1; end
            default:        ;
        endcase
        mask[BTN_X]         = face[4];
        mask[BTN_A]         = face[5];
        mask[BTN_B]         = face[6];
        mask[BTN_Y]         = face[7];
        mask[BTN_LSHOULDER] = shoulder[0];
        mask[BTN_RSHOULDER] = shoulder[1];
        mask[BTN_BACK]      = shoulder[4] | misc[1];
        mask[BTN_START]     = shoulder[5];
        mask[BTN_LTHUMB]    = shoulder[6];
        mask[BTN_RTHUMB]    = shoulder[7];
        return mask;
    endfunction

    task automatic decode_byte(input logic [7:0] data, input logic last);
        int      idx;
        int      base;
        int      r;
        int      need;
        bit      reduced;
        bit      known;
        gphid_pkg::t_result res;
        idx = rpt_len;
        if (idx < REPORT_LIMIT) begin
            if (idx == 0) begin
                rpt_id = data;
            end else begin
                base = (rpt_id == gphid_pkg::ID_FULL_ALT) ? 2 : 1;
                reduced = (rpt_id == gphid_pkg::ID_FULL_USB) && link_bt;
                if (idx >= base) begin
                    r = idx - base;
                    if (reduced) begin
                        if (r < 9) rpt_fields[r] = data;
                    end else if (r < 6) begin
                        rpt_fields[r] = data;
                    end else if (r >= 7 && r < 10) begin
                        rpt_fields[r - 1] = data;
                    end
                end
            end
            rpt_len = idx + 1;
        end
        if (last) begin
            res = '0;
            reduced = (rpt_id == gphid_pkg::ID_FULL_USB) && link_bt;
            known = (rpt_id == gphid_pkg::ID_FULL_USB) || (rpt_id == gphid_pkg::ID_FULL_ALT);
            need = reduced ? int'(gphid_pkg::NEED_REDUCED) :
                   (rpt_id == gphid_pkg::ID_FULL_ALT) ? int'(gphid_pkg::NEED_ALT) :
                   int'(gphid_pkg::NEED_USB);
            if (known && rpt_len >= need) begin
                res.valid_res = 1'b1;
                res.left_x    = scale_axis(rpt_fields[0], 1'b0);
                res.left_y    = scale_axis(rpt_fields[1], 1'b1);
                res.right_x   = scale_axis(rpt_fields[2], 1'b0);
                res.right_y   = scale_axis(rpt_fields[3], 1'b1);
                if (reduced) begin
                    res.trig_left  = rpt_fields[7];
                    res.trig_right = rpt_fields[8];
                    res.buttons = map_hid_buttons(rpt_fields[4], rpt_fields[5], rpt_fields[6]);
                end else begin
                    res.trig_left  = rpt_fields[4];
                    res.trig_right = rpt_fields[5];
                    res.buttons = map_hid_buttons(rpt_fields[6], rpt_fields[7], rpt_fields[8]);
                end
            end
            rpt_len = 0;
            decoded_q.push_back(res);
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(data, last);
        bytes_sent++;
    endtask

    task automatic send_report(input t_report_q rpt);
        for (int i = 0; i < rpt.size(); i++) begin
            send_byte(rpt[i], i == rpt.size() - 1);
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_link_type(input bit bt);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bt;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        link_bt = bt;
    endtask

    task automatic send_random_report();
        t_report_q rpt;
        logic [7:0] id;
        int need;
        int len;
        int pick;
        pick = $urandom_range(99);
        if (pick < 85) begin
            id = $urandom_range(1) ? gphid_pkg::ID_FULL_ALT : gphid_pkg::ID_FULL_USB;
            need = (id == gphid_pkg::ID_FULL_ALT) ? int'(gphid_pkg::NEED_ALT) :
                   link_bt ? int'(gphid_pkg::NEED_REDUCED) : int'(gphid_pkg::NEED_USB);
            pick = $urandom_range(99);
            if (pick < 90) len = need + $urandom_range(4);
            else if (pick < 95) len = $urandom_range(need - 1, 1);
            else len = $urandom_range(LONG_REPORT, need);
        end else begin
            id = 8'($urandom_range(255));
            len = $urandom_range(16, 1);
        end
        rpt.push_back(id);
        for (int i = 1; i < len; i++) rpt.push_back(8'($urandom_range(255)));
        send_report(rpt);
    endtask

    task automatic test_usb_reports();
        t_report_q rpt;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_link_type(1'b0);
        rpt = {gphid_pkg::ID_FULL_USB, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hA5,
               8'hF0, 8'hF3, 8'h02};
        send_report(rpt);
        rpt = {gphid_pkg::ID_FULL_ALT, 8'h77, 8'h80, 8'h80, 8'h01, 8'h7F, 8'hFF, 8'h00,
               8'h3C, 8'h08, 8'h00, 8'h00};
        send_report(rpt);
        rpt = {gphid_pkg::ID_FULL_USB, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70,
               8'h01, 8'hFF};
        send_report(rpt);
        rpt = {8'h02, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70, 8'h03,
               8'hFF, 8'hFF, 8'hFF};
        send_report(rpt);
        rpt = {gphid_pkg::ID_FULL_USB};
        send_report(rpt);
        rpt = {gphid_pkg::ID_FULL_ALT};
        for (int i = 1; i < LONG_REPORT; i++) rpt.push_back(i == 9 ? 8'h0F : 8'(i * 37));
        send_report(rpt);
    endtask

    task automatic test_bluetooth_reports();
        t_report_q rpt;
        write_link_type(1'b1);
        rpt = {gphid_pkg::ID_FULL_USB, 8'h81, 8'h7F, 8'h00, 8'hFF, 8'h17, 8'hC0, 8'h02,
               8'h01, 8'hFE};
        send_report(rpt);
        rpt = {gphid_pkg::ID_FULL_ALT, 8'h00, 8'hFE, 8'h02, 8'h90, 8'h6F, 8'h11, 8'h22,
               8'h00, 8'h8C, 8'h31, 8'h00};
        send_report(rpt);
        rpt = {gphid_pkg::ID_FULL_USB, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE,
               8'hF0};
        send_report(rpt);
    endtask

    task automatic test_random_traffic(input bit bt, input int send_pct, input int recv_pct,
                                       input int num_bytes, input bit with_pause);
        int stop_at;
        bit paused;
        write_link_type(bt);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        stop_at = bytes_sent + num_bytes;
        paused = 1'b0;
        while (bytes_sent < stop_at) begin
            if (with_pause && !paused && bytes_sent >= stop_at - num_bytes / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
            send_random_report();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = gphid_pkg::t_result'(m_axis_tdata[gphid_pkg::RESULT_BITS-1:0]);
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = decoded_q.pop_front();
                check_field("valid_res", 16'(want.valid_res), 16'(got.valid_res));
                check_field("left_x", want.left_x, got.left_x);
                check_field("left_y", want.left_y, got.left_y);
                check_field("right_x", want.right_x, got.right_x);
                check_field("right_y", want.right_y, got.right_y);
                check_field("trig_left", 16'(want.trig_left), 16'(got.trig_left));
                check_field("trig_right", 16'(want.trig_right), 16'(got.trig_right));
                check_field("buttons", 16'(want.buttons), 16'(got.buttons));
                check_field("pad", 16'h0, 16'(m_axis_tdata[95]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("gamepad_hid_report_decoder_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_usb_reports();
        test_bluetooth_reports();
        test_random_traffic(1'b0, 0, 0, 260, 1'b1);
        test_random_traffic(1'b1, 74, 0, 260, 1'b0);
        test_random_traffic(1'b0, 0, 74, 260, 1'b0);
        test_random_traffic(1'b1, 9, 9, 250, 1'b1);
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("gamepad_hid_report_decoder_core regression: pass");
        end else begin
            $display("gamepad_hid_report_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
